>>> sv/pds_pkg.sv
// shared widths, constants and controller/datapath interface types for the pll divider search
`timescale 1ns / 1ps
`default_nettype none
package pds_pkg;

    localparam int FREQ_W = 30;                 // frequency fields
    localparam int DIV_W  = 8;                  // divider counters and limits
    localparam int PROD_W = FREQ_W + DIV_W;     // ref * m at full width

    localparam int DIV_LIMIT_DEF = 255;

    // legal vco window, inclusive
    localparam logic [PROD_W-1:0] VCO_MIN    = PROD_W'(160000000);
    localparam logic [PROD_W-1:0] VCO_MAX_P1 = PROD_W'(600000001);

    localparam logic [DIV_W-1:0] MULT_RST    = DIV_W'(15);
    localparam logic [DIV_W-1:0] PREDIV_RST  = DIV_W'(15);
    localparam logic [DIV_W-1:0] POSTDIV_RST = DIV_W'(7);

    // post divider steps in the {2, 4} mode
    localparam logic [DIV_W-1:0] K_PAIR_FIRST = DIV_W'(2);
    localparam logic [DIV_W-1:0] K_PAIR_LAST  = DIV_W'(4);
    localparam logic [DIV_W-1:0] K_PAIR_STEP  = DIV_W'(2);

    // divider operand select
    localparam logic DIV_SEL_PREDIV  = 1'b0;
    localparam logic DIV_SEL_POSTDIV = 1'b1;

    // config register map, each register at byte address 4 * index
    typedef enum logic [1:0] {
        REG_MAX_MULT,
        REG_MAX_PREDIV,
        REG_MAX_POSTDIV,
        REG_POST_MODE
    } cfg_reg_t;

    typedef struct packed {
        logic start;       // latch item, clear best, m = 1
        logic prod_load;   // prod = ref * m
        logic m_inc;
        logic n_init;
        logic n_inc;
        logic bound_load;  // window bounds scaled by n
        logic div_start;
        logic div_sel;
        logic vco_load;
        logic k_init;
        logic k_inc;
        logic err_load;
        logic best_try;
        logic out_load;
    } pds_cmd_t;

    typedef struct packed {
        logic m_empty;
        logic m_last;
        logic prod_low;
        logic n_empty;
        logic n_last;
        logic vco_bad;
        logic div_done;
        logic k_empty;
        logic k_last;
        logic out_busy;
    } pds_sts_t;

endpackage
`default_nettype wire

>>> sv/pds_div.sv
// restoring divider, one quotient bit per cycle, quotient known to fit FREQ_W bits
`timescale 1ns / 1ps
`default_nettype none
module pds_div
    import pds_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [PROD_W-1:0] dividend,
    input  wire logic [DIV_W-1:0]  divisor,
    output logic                   done,
    output logic [FREQ_W-1:0]      quotient
);

    localparam int CNT_W = $clog2(FREQ_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FREQ_W - 1);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DIV_W-1:0]  rem_reg;
    logic [FREQ_W-1:0] quo_reg;
    logic [DIV_W-1:0]  dsr_reg;

    logic [DIV_W:0]    shifted;
    logic [DIV_W:0]    diff;
    logic              ge;
    logic [DIV_W-1:0]  rem_next;
    logic [FREQ_W-1:0] quo_next;

    always_comb
    begin
        shifted  = {rem_reg, quo_reg[FREQ_W-1]};
        ge       = shifted >= {1'b0, dsr_reg};
        diff     = shifted - {1'b0, dsr_reg};
        rem_next = ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
        quo_next = {quo_reg[FREQ_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_LAST)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // upper dividend bits are below the divisor, so they seed the remainder
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend[PROD_W-1:FREQ_W];
            quo_reg <= dividend[FREQ_W-1:0];
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

`ifndef SYNTH
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while still busy");
`endif

endmodule
`default_nettype wire

>>> sv/pds_datapath.sv
// search datapath: loop counters, products, shared divider, best tracking, output register
`timescale 1ns / 1ps
`default_nettype none
module pds_datapath
    import pds_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [FREQ_W-1:0] ref_hz,
    input  wire logic [FREQ_W-1:0] target_hz,
    input  wire logic [DIV_W-1:0]  mult_lim,
    input  wire logic [DIV_W-1:0]  prediv_lim,
    input  wire logic [DIV_W-1:0]  postdiv_lim,
    input  wire logic              post_mode,
    input  wire pds_cmd_t          cmd,
    output pds_sts_t               sts,
    input  wire logic              out_ready,
    output logic                   out_valid,
    output logic [DIV_W-1:0]       best_mult,
    output logic [DIV_W-1:0]       best_prediv,
    output logic [DIV_W-1:0]       best_postdiv,
    output logic                   found
);

    logic [FREQ_W-1:0] ref_reg;
    logic [FREQ_W-1:0] target_reg;
    logic [DIV_W-1:0]  m_reg;
    logic [DIV_W-1:0]  n_reg;
    logic [DIV_W-1:0]  k_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] lo_reg;
    logic [PROD_W-1:0] hi_reg;
    logic [FREQ_W-1:0] vco_reg;
    logic [FREQ_W-1:0] err_reg;
    logic              have_reg;
    logic [FREQ_W-1:0] best_err_reg;
    logic [FREQ_W-1:0] best_vco_reg;
    logic [DIV_W-1:0]  bm_reg;
    logic [DIV_W-1:0]  bn_reg;
    logic [DIV_W-1:0]  bk_reg;
    logic              out_valid_reg;
    logic [DIV_W-1:0]  out_m_reg;
    logic [DIV_W-1:0]  out_n_reg;
    logic [DIV_W-1:0]  out_k_reg;
    logic              out_found_reg;

    logic [PROD_W-1:0] div_dividend;
    logic [DIV_W-1:0]  div_divisor;
    logic              div_done;
    logic [FREQ_W-1:0] div_q;
    logic [FREQ_W-1:0] err_next;
    logic              better;
    logic [DIV_W-1:0]  k_first;
    logic [DIV_W-1:0]  k_step;

    assign div_dividend = (cmd.div_sel == DIV_SEL_POSTDIV) ? PROD_W'(vco_reg) : prod_reg;
    assign div_divisor  = (cmd.div_sel == DIV_SEL_POSTDIV) ? k_reg : n_reg;

    pds_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        k_first  = post_mode ? K_PAIR_FIRST : DIV_W'(1);
        k_step   = post_mode ? K_PAIR_STEP : DIV_W'(1);
        err_next = (div_q > target_reg) ? (div_q - target_reg) : (target_reg - div_q);
        // smaller error wins, then higher vco, then earlier candidate
        better   = !have_reg || (err_reg < best_err_reg)
                   || ((err_reg == best_err_reg) && (vco_reg > best_vco_reg));
    end

    always_comb
    begin
        sts.m_empty  = mult_lim == '0;
        sts.m_last   = m_reg == mult_lim;
        sts.prod_low = prod_reg < VCO_MIN;
        sts.n_empty  = prediv_lim == '0;
        sts.n_last   = n_reg == prediv_lim;
        sts.vco_bad  = (prod_reg < lo_reg) || (prod_reg >= hi_reg);
        sts.div_done = div_done;
        sts.k_empty  = !post_mode && (postdiv_lim == '0);
        sts.k_last   = post_mode ? (k_reg == K_PAIR_LAST) : (k_reg == postdiv_lim);
        sts.out_busy = out_valid_reg && !out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.start)
                have_reg <= 1'b0;
            else if (cmd.best_try)
                have_reg <= 1'b1;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            ref_reg    <= ref_hz;
            target_reg <= target_hz;
            m_reg      <= DIV_W'(1);
            bm_reg     <= '0;
            bn_reg     <= '0;
            bk_reg     <= '0;
        end
        else if (cmd.best_try && better)
        begin
            best_err_reg <= err_reg;
            best_vco_reg <= vco_reg;
            bm_reg       <= m_reg;
            bn_reg       <= n_reg;
            bk_reg       <= k_reg;
        end
        if (cmd.m_inc)
            m_reg <= m_reg + DIV_W'(1);
        if (cmd.prod_load)
            prod_reg <= PROD_W'(ref_reg) * PROD_W'(m_reg);
        if (cmd.n_init)
            n_reg <= DIV_W'(1);
        else if (cmd.n_inc)
            n_reg <= n_reg + DIV_W'(1);
        if (cmd.bound_load)
        begin
            lo_reg <= PROD_W'(n_reg) * VCO_MIN;
            hi_reg <= PROD_W'(n_reg) * VCO_MAX_P1;
        end
        if (cmd.vco_load)
            vco_reg <= div_q;
        if (cmd.k_init)
            k_reg <= k_first;
        else if (cmd.k_inc)
            k_reg <= k_reg + k_step;
        if (cmd.err_load)
            err_reg <= err_next;
        if (cmd.out_load)
        begin
            out_m_reg     <= bm_reg;
            out_n_reg     <= bn_reg;
            out_k_reg     <= bk_reg;
            out_found_reg <= have_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign best_mult    = out_m_reg;
    assign best_prediv  = out_n_reg;
    assign best_postdiv = out_k_reg;
    assign found        = out_found_reg;

`ifndef SYNTH
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !sts.out_busy)
        else $error("result register overwritten before transfer");
    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_found_reg |->
            out_m_reg == '0 && out_n_reg == '0 && out_k_reg == '0)
        else $error("nonzero dividers reported with no match");
    a_found_set: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_found_reg |->
            out_m_reg != '0 && out_n_reg != '0 && out_k_reg != '0)
        else $error("match reported with a zero divider");
`endif

endmodule
`default_nettype wire

>>> sv/pds_ctrl.sv
// search sequencer: walks m, n, k and drives the datapath
`timescale 1ns / 1ps
`default_nettype none
module pds_ctrl
    import pds_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire pds_sts_t sts,
    output pds_cmd_t      cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_MPROD  = 4'd1;
    localparam logic [3:0] S_MCHK   = 4'd2;
    localparam logic [3:0] S_NMUL   = 4'd3;
    localparam logic [3:0] S_NCHK   = 4'd4;
    localparam logic [3:0] S_NDIV   = 4'd5;
    localparam logic [3:0] S_KSTART = 4'd6;
    localparam logic [3:0] S_KDIV   = 4'd7;
    localparam logic [3:0] S_KUPD   = 4'd8;
    localparam logic [3:0] S_NEXTN  = 4'd9;
    localparam logic [3:0] S_NEXTM  = 4'd10;
    localparam logic [3:0] S_DONE   = 4'd11;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = sts.m_empty ? S_DONE : S_MPROD;
                end
            end
            S_MPROD:
            begin
                cmd.prod_load = 1'b1;
                state_next    = S_MCHK;
            end
            S_MCHK:
            begin
                if (sts.prod_low || sts.n_empty)
                    state_next = S_NEXTM;
                else
                begin
                    cmd.n_init = 1'b1;
                    state_next = S_NMUL;
                end
            end
            S_NMUL:
            begin
                cmd.bound_load = 1'b1;
                state_next     = S_NCHK;
            end
            S_NCHK:
            begin
                if (sts.vco_bad)
                    state_next = S_NEXTN;
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_SEL_PREDIV;
                    state_next    = S_NDIV;
                end
            end
            S_NDIV:
            begin
                if (sts.div_done)
                begin
                    cmd.vco_load = 1'b1;
                    cmd.k_init   = 1'b1;
                    state_next   = sts.k_empty ? S_NEXTN : S_KSTART;
                end
            end
            S_KSTART:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_SEL_POSTDIV;
                state_next    = S_KDIV;
            end
            S_KDIV:
            begin
                if (sts.div_done)
                begin
                    cmd.err_load = 1'b1;
                    state_next   = S_KUPD;
                end
            end
            S_KUPD:
            begin
                cmd.best_try = 1'b1;
                if (sts.k_last)
                    state_next = S_NEXTN;
                else
                begin
                    cmd.k_inc  = 1'b1;
                    state_next = S_KSTART;
                end
            end
            S_NEXTN:
            begin
                if (sts.n_last)
                    state_next = S_NEXTM;
                else
                begin
                    cmd.n_inc  = 1'b1;
                    state_next = S_NMUL;
                end
            end
            S_NEXTM:
            begin
                if (sts.m_last)
                    state_next = S_DONE;
                else
                begin
                    cmd.m_inc  = 1'b1;
                    state_next = S_MPROD;
                end
            end
            S_DONE:
            begin
                if (!sts.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule
`default_nettype wire

>>> sv/pll_divider_search_core.sv
// top level of the pll divider search: config registers, sequencer and datapath
//
// usage
//   input channel (in_valid/in_ready) carries ref_hz and target_hz; output
//   channel (out_valid/out_ready) returns best_mult, best_prediv,
//   best_postdiv and found, exactly one result transfer per input transfer
//   one item is searched at a time; in_ready is high only while the
//   sequencer is idle, so a new item is taken only after a search ends
//   every m, every n whose vco lands in the window and every k is tried,
//   using the shared one bit per cycle divider (30 steps per quotient)
//   once for vco = ref*m/n and once per k for vco/k; m values whose ref*m
//   is below the window and out of window n values skip the divider
//   the result sits in an output register; a new item is taken while it
//   waits, and a finished search holds in its last state while the
//   receiver stalls with the previous result still pending
//   reset: channels go idle, registers return to m 15, n 15, k 7, mode 0
//   apb: max_mult at 0x0, max_prediv 0x4, max_postdiv 0x8, post_mode 0xc;
//   write only while idle; pready is tied high
`timescale 1ns / 1ps
`default_nettype none
module pll_divider_search_core
    import pds_pkg::*;
#(
    parameter int DIV_LIMIT = DIV_LIMIT_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // apb config port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [3:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    // request channel
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [FREQ_W-1:0] ref_hz,
    input  wire logic [FREQ_W-1:0] target_hz,
    // result channel
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [DIV_W-1:0]       best_mult,
    output logic [DIV_W-1:0]       best_prediv,
    output logic [DIV_W-1:0]       best_postdiv,
    output logic                   found
);

    localparam logic [DIV_W-1:0] LIMIT = DIV_W'(DIV_LIMIT);

    logic [DIV_W-1:0] max_mult_reg;
    logic [DIV_W-1:0] max_prediv_reg;
    logic [DIV_W-1:0] max_postdiv_reg;
    logic             post_mode_reg;

    logic             wr_en;
    logic [1:0]       reg_idx;
    logic [DIV_W-1:0] mult_lim;
    logic [DIV_W-1:0] prediv_lim;
    logic [DIV_W-1:0] postdiv_lim;

    pds_cmd_t cmd;
    pds_sts_t sts;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_mult_reg    <= MULT_RST;
            max_prediv_reg  <= PREDIV_RST;
            max_postdiv_reg <= POSTDIV_RST;
            post_mode_reg   <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_MAX_MULT:    max_mult_reg    <= pwdata[DIV_W-1:0];
                REG_MAX_PREDIV:  max_prediv_reg  <= pwdata[DIV_W-1:0];
                REG_MAX_POSTDIV: max_postdiv_reg <= pwdata[DIV_W-1:0];
                REG_POST_MODE:   post_mode_reg   <= pwdata[0];
                default:         ;
            endcase
        end
    end

    // read back the stored register value
    always_comb
    begin
        unique case (reg_idx)
            REG_MAX_MULT:    prdata = 32'(max_mult_reg);
            REG_MAX_PREDIV:  prdata = 32'(max_prediv_reg);
            REG_MAX_POSTDIV: prdata = 32'(max_postdiv_reg);
            REG_POST_MODE:   prdata = 32'(post_mode_reg);
            default:         prdata = '0;
        endcase
    end

    // limits above the build-time divider limit are clamped
    assign mult_lim    = (max_mult_reg > LIMIT) ? LIMIT : max_mult_reg;
    assign prediv_lim  = (max_prediv_reg > LIMIT) ? LIMIT : max_prediv_reg;
    assign postdiv_lim = (max_postdiv_reg > LIMIT) ? LIMIT : max_postdiv_reg;

    pds_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pds_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ref_hz       (ref_hz),
        .target_hz    (target_hz),
        .mult_lim     (mult_lim),
        .prediv_lim   (prediv_lim),
        .postdiv_lim  (postdiv_lim),
        .post_mode    (post_mode_reg),
        .cmd          (cmd),
        .sts          (sts),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .best_mult    (best_mult),
        .best_prediv  (best_prediv),
        .best_postdiv (best_postdiv),
        .found        (found)
    );

endmodule
`default_nettype wire

>>> bench/pll_divider_search_core_tb.sv
// self-checking testbench for pll_divider_search_core: directed and random search requests
`timescale 1ns / 1ps
module pll_divider_search_core_tb;
    import pds_pkg::*;

    typedef struct packed {
        logic [DIV_W-1:0] mult;
        logic [DIV_W-1:0] prediv;
        logic [DIV_W-1:0] postdiv;
        logic             found;
    } pll_choice_t;

    // the watchdog limit has to cover the longest search that this bench
    // requests plus a long receiver stall
    localparam int WATCHDOG_LIMIT = 800000;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_ITEMS    = 50;

    // keeps its own copy of the limit registers and predicts the chosen
    // divider triple for every request transfer
    class pll_search_scoreboard;
        logic [DIV_W-1:0] mult_lim    = MULT_RST;
        logic [DIV_W-1:0] prediv_lim  = PREDIV_RST;
        logic [DIV_W-1:0] postdiv_lim = POSTDIV_RST;
        logic             pair_mode   = 1'b0;
        pll_choice_t      expected_choices[$];
        int               mismatches  = 0;
        int               requests    = 0;
        int               results     = 0;
        int               locked      = 0;

        function void set_register(cfg_reg_t idx, logic [31:0] value);
            case (idx)
                REG_MAX_MULT:    mult_lim    = value[DIV_W-1:0];
                REG_MAX_PREDIV:  prediv_lim  = value[DIV_W-1:0];
                REG_MAX_POSTDIV: postdiv_lim = value[DIV_W-1:0];
                REG_POST_MODE:   pair_mode   = value[0];
            endcase
        endfunction

        function int clamp_limit(logic [DIV_W-1:0] v);
            return (int'(v) > DIV_LIMIT_DEF) ? DIV_LIMIT_DEF : int'(v);
        endfunction

        // exhaustive walk, m then n then k ascending; strict compares keep
        // the earliest candidate on a full tie
        function pll_choice_t search_best(logic [FREQ_W-1:0] fref, logic [FREQ_W-1:0] ftgt);
            pll_choice_t       pick;
            logic [PROD_W-1:0] prod;
            logic [PROD_W-1:0] vco;
            logic [PROD_W-1:0] fout;
            logic [PROD_W-1:0] err;
            logic [PROD_W-1:0] best_err;
            logic [PROD_W-1:0] best_vco;
            logic [PROD_W-1:0] tgt_w;
            int                m_top;
            int                n_top;
            int                k_lo;
            int                k_hi;
            int                k_step;
            pick     = '0;
            best_err = '0;
            best_vco = '0;
            tgt_w    = PROD_W'(ftgt);
            m_top    = clamp_limit(mult_lim);
            n_top    = clamp_limit(prediv_lim);
            if (pair_mode)
            begin
                k_lo   = int'(K_PAIR_FIRST);
                k_hi   = int'(K_PAIR_LAST);
                k_step = int'(K_PAIR_STEP);
            end
            else
            begin
                k_lo   = 1;
                k_hi   = clamp_limit(postdiv_lim);
                k_step = 1;
            end
            for (int m = 1; m <= m_top; m++)
            begin
                prod = PROD_W'(fref) * PROD_W'(m);
                if (prod < VCO_MIN)
                    continue;
                for (int n = 1; n <= n_top; n++)
                begin
                    vco = prod / PROD_W'(n);
                    if (vco < VCO_MIN || vco >= VCO_MAX_P1)
                        continue;
                    for (int k = k_lo; k <= k_hi; k += k_step)
                    begin
                        fout = vco / PROD_W'(k);
                        err  = (fout > tgt_w) ? fout - tgt_w : tgt_w - fout;
                        if (!pick.found || err < best_err ||
                            (err == best_err && vco > best_vco))
                        begin
                            pick.found   = 1'b1;
                            pick.mult    = DIV_W'(m);
                            pick.prediv  = DIV_W'(n);
                            pick.postdiv = DIV_W'(k);
                            best_err     = err;
                            best_vco     = vco;
                        end
                    end
                end
            end
            return pick;
        endfunction

        function void note_request(logic [FREQ_W-1:0] fref, logic [FREQ_W-1:0] ftgt);
            expected_choices.push_back(search_best(fref, ftgt));
            requests++;
        endfunction

        function void check_result(pll_choice_t got);
            pll_choice_t want;
            results++;
            if (got.found === 1'b1)
                locked++;
            if (expected_choices.size() == 0)
            begin
                $error("result transfer with no request outstanding: m %0d n %0d k %0d found %0d",
                       got.mult, got.prediv, got.postdiv, got.found);
                mismatches++;
                return;
            end
            want = expected_choices.pop_front();
            if (got.mult !== want.mult)
            begin
                $error("best_mult: expected %0d, got %0d", want.mult, got.mult);
                mismatches++;
            end
            if (got.prediv !== want.prediv)
            begin
                $error("best_prediv: expected %0d, got %0d", want.prediv, got.prediv);
                mismatches++;
            end
            if (got.postdiv !== want.postdiv)
            begin
                $error("best_postdiv: expected %0d, got %0d", want.postdiv, got.postdiv);
                mismatches++;
            end
            if (got.found !== want.found)
            begin
                $error("found: expected %0d, got %0d", want.found, got.found);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_choices.size();
        endfunction
    endclass

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              psel      = 1'b0;
    logic              penable   = 1'b0;
    logic              pwrite    = 1'b0;
    logic [3:0]        paddr     = '0;
    logic [31:0]       pwdata    = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    logic [FREQ_W-1:0] ref_hz    = '0;
    logic [FREQ_W-1:0] target_hz = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [DIV_W-1:0]  best_mult;
    logic [DIV_W-1:0]  best_prediv;
    logic [DIV_W-1:0]  best_postdiv;
    logic              found;

    pll_search_scoreboard sb;

    int burst_left     = 0;
    int settings_used  = 1;   // reset values count as the first setting
    int stuck_cycles   = 0;
    int stall_left     = 0;
    int rx_window      = 0;
    bit rx_calm        = 1'b0;

    pll_divider_search_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .ref_hz       (ref_hz),
        .target_hz    (target_hz),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .best_mult    (best_mult),
        .best_prediv  (best_prediv),
        .best_postdiv (best_postdiv),
        .found        (found)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // result receiver: random windows, calm or with short and
    // long stalls, so a pending result waits at different points of a search
    always @(negedge clk)
    begin
        if (rx_window == 0)
        begin
            rx_window = $urandom_range(1000, 6000);
            rx_calm   = ($urandom_range(0, 2) == 0);
        end
        else
            rx_window--;
        if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            out_ready <= 1'b1;
            if (!rx_calm && $urandom_range(0, 5) == 0)
                stall_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 600)
                                                         : $urandom_range(1, 6);
        end
    end

    // result monitor, sampled at the rising edge
    always @(posedge clk)
    begin
        pll_choice_t seen;
        if (rst_n && out_valid && out_ready)
        begin
            seen = '{best_mult, best_prediv, best_postdiv, found};
            sb.check_result(seen);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stuck_cycles = 0;
        else if (stuck_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", stuck_cycles);
            $display("== FAIL ==");
            $finish;
        end
        else
            stuck_cycles++;
    end

    // one request transfer; the sender runs in bursts with random gaps,
    // valid stays high across back to back items inside a burst
    task automatic push_request(input logic [FREQ_W-1:0] fref, input logic [FREQ_W-1:0] ftgt);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 400)
                                                     : $urandom_range(0, 4);
            burst_left = $urandom_range(1, 8);
            repeat (gap)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
        end
        @(negedge clk);
        in_valid  <= 1'b1;
        ref_hz    <= fref;
        target_hz <= ftgt;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_request(fref, ftgt);
        burst_left--;
    endtask

    // stop sending and wait until every result is back and the sequencer idles
    task automatic settle_search();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // apb write followed by a read back of the same register; upper pwdata
    // bits carry noise that the register must drop
    task automatic write_reg(input cfg_reg_t idx, input logic [DIV_W-1:0] value);
        logic [31:0] mask;
        logic [31:0] word;
        logic [31:0] readback;
        mask = (idx == REG_POST_MODE) ? 32'h1 : 32'hff;
        word = ($urandom() & ~mask) | (32'(value) & mask);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(negedge clk);
        penable <= 1'b1;
        // straight into the read setup phase
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        readback = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.set_register(idx, word);
        if (readback !== (word & mask))
        begin
            $error("%s read back: expected %0d, got %0d", idx.name(), word & mask, readback);
            sb.mismatches++;
        end
    endtask

    task automatic program_search(input logic [DIV_W-1:0] mult, input logic [DIV_W-1:0] prediv,
                                  input logic [DIV_W-1:0] postdiv, input logic pair);
        settle_search();
        write_reg(REG_MAX_MULT, mult);
        write_reg(REG_MAX_PREDIV, prediv);
        write_reg(REG_MAX_POSTDIV, postdiv);
        write_reg(REG_POST_MODE, DIV_W'(pair));
        settings_used++;
    endtask

    // mostly references that can land in the vco window with small limits,
    // some tiny ones and some over the whole field
    function automatic logic [FREQ_W-1:0] pick_ref_hz();
        case ($urandom_range(0, 9))
            0:       return FREQ_W'($urandom());
            1:       return FREQ_W'($urandom_range(0, 2000000));
            default: return FREQ_W'($urandom_range(20000000, 700000000));
        endcase
    endfunction

    function automatic logic [FREQ_W-1:0] pick_target_hz();
        case ($urandom_range(0, 9))
            0:       return FREQ_W'($urandom());
            1:       return FREQ_W'($urandom_range(0, 1000));
            default: return FREQ_W'($urandom_range(0, 600000000));
        endcase
    endfunction

    initial
    begin
        sb = new();
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // reset limits (15, 15, 7, k stepping)
        push_request(25000000, 100000000);
        push_request(0, 0);                         // zero reference
        push_request(100000000, 0);
        push_request(30'h3fff_ffff, 30'h3fff_ffff); // both fields at full scale
        push_request(10000000, 1);                  // ref * 15 below the window
        push_request(160000000, 160000000);         // vco on the low bound
        push_request(600000000, 600000000);         // vco on the high bound
        push_request(600000001, 150000000);         // just above the window at n = 1

        // k in {2, 4}
        program_search(15, 15, 7, 1'b1);
        push_request(50000000, 75000000);
        push_request(200000000, 1);
        push_request(30'h2aaa_aaaa, 30'h1555_5555);

        // empty divider ranges
        program_search(0, 15, 7, 1'b0);
        push_request(100000000, 50000000);
        program_search(15, 0, 7, 1'b0);
        push_request(100000000, 50000000);
        program_search(15, 15, 0, 1'b0);
        push_request(100000000, 50000000);
        program_search(15, 15, 0, 1'b1);            // postdiv limit ignored in pair mode
        push_request(100000000, 50000000);

        // one limit at the top, the others minimal
        program_search(255, 1, 1, 1'b0);
        push_request(1000000, 200000000);
        push_request(30'h3fff_ffff, 0);
        program_search(1, 255, 1, 1'b0);
        push_request(1000000000, 100000000);
        push_request(30'h3fff_ffff, 30'h2aaa_aaaa);
        program_search(1, 1, 255, 1'b0);
        push_request(600000000, 2400000);
        push_request(300000000, 1);

        // everything at the top; a low reference keeps the search short
        program_search(255, 255, 255, 1'b1);
        push_request(1000000, 60000000);

        // random phases with small limits
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            program_search(DIV_W'($urandom_range(1, 8)), DIV_W'($urandom_range(1, 3)),
                           DIV_W'($urandom_range(1, 3)), 1'($urandom_range(0, 1)));
            repeat (PHASE_ITEMS)
                push_request(pick_ref_hz(), pick_target_hz());
        end

        settle_search();
        // catch any stray result transfer
        repeat (500) @(posedge clk);

        $display("covered %0d search requests over %0d limit settings",
                 sb.requests, settings_used);
        $display("%0d results checked, %0d with a legal vco, %0d mismatches",
                 sb.results, sb.locked, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> pll_divider_search_core.f
sv/pds_pkg.sv
sv/pds_div.sv
sv/pds_datapath.sv
sv/pds_ctrl.sv
sv/pll_divider_search_core.sv
bench/pll_divider_search_core_tb.sv
